// ===== hw/rtl/uld_pkg.sv =====
// ---------------------------------------------------------------------------
// uld_pkg: shared constants and types for the uu line decoder
// Character codes, line limits and the pending result job record.
// ---------------------------------------------------------------------------
package uld_pkg;

  // character codes
  localparam logic [7:0] CHAR_NEWLINE    = 8'd10;
  localparam logic [7:0] CHAR_SPACE      = 8'd32;
  localparam logic [7:0] CHAR_LAST_VALID = 8'd96;

  // bytes a line may announce
  localparam int unsigned MAX_LINE_BYTES = 45;
  localparam logic [7:0]  CHAR_LAST_LEN  = CHAR_SPACE + 8'(MAX_LINE_BYTES);

  // widths of the line bookkeeping
  localparam int unsigned POS_W   = 7;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned SEXT_W  = 6;

  // results still owed for one accepted transaction
  typedef struct packed {
    logic [23:0]        word;       // decoded group, next byte in the low bits
    logic [1:0]         word_bytes; // bytes of word still to send
    logic [COUNT_W-1:0] pad_bytes;  // zero bytes still to send
    logic               done;       // done result still to send
    logic               err;        // error flag carried by the done result
  } job_t;

endpackage

// ===== hw/rtl/uu_line_decoder_top.sv =====
// ---------------------------------------------------------------------------
// uu_line_decoder_top: streaming uudecode, one character per transaction
// Decodes length-prefixed uuencoded lines into bytes, pads short lines
// with zeros and reports a sticky line-length error at end of text.
//
//   channel | signals                                     | role
//   --------+---------------------------------------------+-------------------
//   in      | in_valid in_ready char_code end_of_text     | text characters
//   out     | out_valid out_ready data_byte is_data       | decoded results
//           | done_res decode_error last                  |
//
// One character is taken per cycle unless an earlier one still has results
// pending; its line state is updated in the same cycle and the results it
// causes are held in a job register, which sends one result per cycle while
// out_ready is high: a group close gives up to three results, a newline up
// to 45 and end of text up to 46, during which input stalls.
// in_ready stays high on the cycle the last result of a job is taken.
// rst is synchronous and clears line state, the error flag and the job.
// ---------------------------------------------------------------------------
module uu_line_decoder_top
  import uld_pkg::*;
#(
  parameter int unsigned MAX_LINE_CHARS = 126
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       is_data,
  output logic       done_res,
  output logic       decode_error,
  output logic       last
);

  // line state
  logic [POS_W-1:0]     line_position, line_position_next;
  logic                 line_active, line_active_next;
  logic [COUNT_W-1:0]   line_byte_count, line_byte_count_next;
  logic [COUNT_W-1:0]   bytes_emitted, bytes_emitted_next;
  logic [3*SEXT_W-1:0]  group_sextets, group_sextets_next;
  logic [1:0]           group_position, group_position_next;
  logic                 group_broken, group_broken_next;
  logic                 error_seen, error_seen_next;

  // pending results
  job_t job, job_next, job_new;

  logic                 in_fire, out_fire, busy, final_result;
  logic [COUNT_W-1:0]   remaining;
  logic [1:0]           word_take;
  logic [1:0]           fin_word_bytes;
  logic                 sext_ok;
  logic [7:0]           sext_full;
  logic [SEXT_W-1:0]    sextet;

  // output side of the job
  assign busy      = (job.word_bytes != 2'd0) || (job.pad_bytes != '0) || job.done;
  assign out_valid = busy;
  assign is_data   = (job.word_bytes != 2'd0) || (job.pad_bytes != '0);
  assign data_byte = (job.word_bytes != 2'd0) ? job.word[7:0] : 8'd0;
  assign done_res  = !is_data && job.done;
  assign decode_error = done_res && job.err;

  assign final_result =
      ((job.word_bytes == 2'd1) && (job.pad_bytes == '0) && !job.done) ||
      ((job.word_bytes == 2'd0) && (job.pad_bytes == COUNT_W'(1)) && !job.done) ||
      ((job.word_bytes == 2'd0) && (job.pad_bytes == '0) && job.done);
  assign last = final_result;

  assign out_fire = out_valid && out_ready;
  assign in_ready = !busy || (out_ready && final_result);
  assign in_fire  = in_valid && in_ready;

  // bytes that the next group or the line end may still send
  assign remaining      = line_byte_count - bytes_emitted;
  assign word_take      = (remaining >= COUNT_W'(3)) ? 2'd3 : remaining[1:0];
  assign fin_word_bytes = (line_active && (group_position != 2'd0)) ? word_take : 2'd0;

  // sextet of a group character
  assign sext_ok   = !group_broken && (char_code >= CHAR_SPACE) &&
                     (char_code <= CHAR_LAST_VALID);
  assign sext_full = char_code - CHAR_SPACE;
  assign sextet    = sext_ok ? sext_full[SEXT_W-1:0] : '0;

  // next line state and the job for this character
  always_comb begin
    line_position_next   = line_position;
    line_active_next     = line_active;
    line_byte_count_next = line_byte_count;
    bytes_emitted_next   = bytes_emitted;
    group_sextets_next   = group_sextets;
    group_position_next  = group_position;
    group_broken_next    = group_broken;
    error_seen_next      = error_seen;
    job_new              = '0;

    if (end_of_text) begin
      if (!error_seen && line_active) begin
        job_new.word       = {{SEXT_W{1'b0}}, group_sextets};
        job_new.word_bytes = fin_word_bytes;
        job_new.pad_bytes  = remaining - COUNT_W'(fin_word_bytes);
      end
      job_new.done         = 1'b1;
      job_new.err          = error_seen;
      line_position_next   = '0;
      line_active_next     = 1'b0;
      line_byte_count_next = '0;
      bytes_emitted_next   = '0;
      group_sextets_next   = '0;
      group_position_next  = 2'd0;
      group_broken_next    = 1'b0;
      error_seen_next      = 1'b0;
    end else if (error_seen) begin
      // text after a too-long line is dropped
    end else if (char_code == CHAR_NEWLINE) begin
      if (line_active) begin
        job_new.word       = {{SEXT_W{1'b0}}, group_sextets};
        job_new.word_bytes = fin_word_bytes;
        job_new.pad_bytes  = remaining - COUNT_W'(fin_word_bytes);
      end
      line_position_next   = '0;
      line_active_next     = 1'b0;
      line_byte_count_next = '0;
      bytes_emitted_next   = '0;
      group_sextets_next   = '0;
      group_position_next  = 2'd0;
      group_broken_next    = 1'b0;
    end else if (line_position >= POS_W'(MAX_LINE_CHARS)) begin
      error_seen_next      = 1'b1;
      line_position_next   = '0;
      line_active_next     = 1'b0;
      line_byte_count_next = '0;
      bytes_emitted_next   = '0;
      group_sextets_next   = '0;
      group_position_next  = 2'd0;
      group_broken_next    = 1'b0;
    end else begin
      line_position_next = line_position + POS_W'(1);
      if (line_position == '0) begin
        // length character
        if ((char_code > CHAR_SPACE) && (char_code <= CHAR_LAST_LEN)) begin
          line_active_next     = 1'b1;
          line_byte_count_next = sext_full[COUNT_W-1:0];
          bytes_emitted_next   = '0;
        end
      end else if (line_active) begin
        if (!sext_ok) begin
          group_broken_next = 1'b1;
        end
        if (group_position == 2'd3) begin
          // group complete
          job_new.word        = {sextet, group_sextets};
          job_new.word_bytes  = word_take;
          bytes_emitted_next  = bytes_emitted + COUNT_W'(word_take);
          group_sextets_next  = '0;
          group_position_next = 2'd0;
          group_broken_next   = 1'b0;
        end else begin
          case (group_position)
            2'd0:    group_sextets_next = {group_sextets[17:6], sextet};
            2'd1:    group_sextets_next = {group_sextets[17:12], sextet,
                                           group_sextets[5:0]};
            default: group_sextets_next = {sextet, group_sextets[11:0]};
          endcase
          group_position_next = group_position + 2'd1;
        end
      end
    end
  end

  // job register advance
  always_comb begin
    job_next = job;
    if (in_fire) begin
      job_next = job_new;
    end else if (out_fire) begin
      if (job.word_bytes != 2'd0) begin
        job_next.word_bytes = job.word_bytes - 2'd1;
        job_next.word       = {8'd0, job.word[23:8]};
      end else if (job.pad_bytes != '0) begin
        job_next.pad_bytes = job.pad_bytes - COUNT_W'(1);
      end else begin
        job_next.done = 1'b0;
      end
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_position   <= '0;
      line_active     <= 1'b0;
      line_byte_count <= '0;
      bytes_emitted   <= '0;
      group_sextets   <= '0;
      group_position  <= 2'd0;
      group_broken    <= 1'b0;
      error_seen      <= 1'b0;
      job             <= '0;
    end else begin
      if (in_fire) begin
        line_position   <= line_position_next;
        line_active     <= line_active_next;
        line_byte_count <= line_byte_count_next;
        bytes_emitted   <= bytes_emitted_next;
        group_sextets   <= group_sextets_next;
        group_position  <= group_position_next;
        group_broken    <= group_broken_next;
        error_seen      <= error_seen_next;
      end
      job <= job_next;
    end
  end

endmodule

// ===== hw/rtl/uld_checker.sv =====
// ---------------------------------------------------------------------------
// uld_checker: port-level checks for the uu line decoder
// Watches the output channel for consistent result flags over time.
// ---------------------------------------------------------------------------
module uld_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] data_byte,
  input logic       is_data,
  input logic       done_res,
  input logic       decode_error,
  input logic       last
);

  // a result never carries both a byte and done
  a_data_xor_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_data && done_res))
    else $error("result carries both data and done");

  // error flag and nonzero byte only where they belong
  a_flags_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((!decode_error || done_res) && (is_data || data_byte == 8'd0)))
    else $error("stray error flag or byte on result");

  // done is always the final result of its transaction
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> last)
    else $error("done result not marked last");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(data_byte) &&
                                   $stable(last) && $stable(done_res)))
    else $error("stalled result changed");

endmodule

bind uu_line_decoder_top uld_checker u_uld_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .data_byte    (data_byte),
  .is_data      (is_data),
  .done_res     (done_res),
  .decode_error (decode_error),
  .last         (last)
);

// ===== bench/tb_uu_line_decoder_top.sv =====
// ---------------------------------------------------------------------------
// tb_uu_line_decoder_top: self-checking bench for the uu line decoder
// Streams encoded text into the block one character per transaction and
// predicts every decoded byte, zero pad and done result in a scoreboard
// class. Covers directed corner lines, random texts, a line that runs to the
// character limit and past it, and three sender/receiver idling mixes.
// ---------------------------------------------------------------------------
module tb_uu_line_decoder_top;
  import uld_pkg::*;

  localparam int unsigned MAX_LINE_CHARS = 126;
  localparam int unsigned CYCLE_LIMIT    = 300000;
  localparam int unsigned DRAIN_CYCLES   = 64;

  // one result as seen on the output channel
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_data;
    logic       done;
    logic       err;
    logic       last;
  } uu_out_t;

  // decoder prediction and the results it still owes
  class uu_decode_board;
    uu_out_t     owed[$];
    int unsigned fail_count;
    int unsigned results_checked;
    int unsigned texts_done;
    int unsigned texts_failed;

    bit [POS_W-1:0]   line_pos;
    bit               line_on;
    bit [COUNT_W-1:0] byte_count;
    bit [COUNT_W-1:0] sent;
    bit [17:0]        sextets;
    bit [1:0]         grp_pos;
    bit               grp_bad;
    bit               err_sticky;

    function new();
      clear_line();
      err_sticky = 1'b0;
    endfunction

    function void clear_line();
      line_pos   = '0;
      line_on    = 1'b0;
      byte_count = '0;
      sent       = '0;
      sextets    = '0;
      grp_pos    = '0;
      grp_bad    = 1'b0;
    endfunction

    function void push_result(logic [7:0] b, logic isd, logic done, logic err);
      uu_out_t r;
      r.data_byte = b;
      r.is_data   = isd;
      r.done      = done;
      r.err       = err;
      r.last      = 1'b0;
      owed.push_back(r);
    endfunction

    // bytes of one group, low byte first, never past the announced count
    function void emit_group(logic [23:0] word);
      for (int j = 0; j < 3; j++) begin
        if (sent < byte_count) begin
          push_result(word[8*j +: 8], 1'b1, 1'b0, 1'b0);
          sent = sent + 1'b1;
        end
      end
    endfunction

    // flush a partial group, then zero pad up to the count
    function void close_line();
      if (line_on) begin
        if (grp_pos != 2'd0) emit_group({6'd0, sextets});
        while (sent < byte_count) begin
          push_result(8'h00, 1'b1, 1'b0, 1'b0);
          sent = sent + 1'b1;
        end
      end
      clear_line();
    endfunction

    // note one accepted input transaction and queue what it causes
    function void note_char(logic [7:0] c, logic eot);
      int unsigned owed_before;
      logic        was_err;
      logic [7:0]  diff;
      logic [5:0]  sext;
      uu_out_t     tail;
      owed_before = owed.size();
      diff = c - CHAR_SPACE;
      if (eot) begin
        was_err = err_sticky;
        if (!err_sticky) close_line();
        push_result(8'h00, 1'b0, 1'b1, was_err);
        texts_done++;
        if (was_err) texts_failed++;
        clear_line();
        err_sticky = 1'b0;
      end else if (err_sticky) begin
        // everything up to end of text is dropped
      end else if (c == CHAR_NEWLINE) begin
        close_line();
      end else if (line_pos >= MAX_LINE_CHARS) begin
        err_sticky = 1'b1;
        clear_line();
      end else begin
        line_pos = line_pos + 1'b1;
        if (line_pos == 1) begin
          if (c > CHAR_SPACE && c <= CHAR_LAST_LEN) begin
            line_on    = 1'b1;
            byte_count = diff[5:0];
            sent       = '0;
          end
        end else if (line_on) begin
          sext = 6'd0;
          if (!grp_bad && c >= CHAR_SPACE && c <= CHAR_LAST_VALID) sext = diff[5:0];
          else grp_bad = 1'b1;
          if (grp_pos == 2'd3) begin
            emit_group({sext, sextets});
            sextets = '0;
            grp_pos = '0;
            grp_bad = 1'b0;
          end else begin
            sextets = sextets | ({12'd0, sext} << (6 * grp_pos));
            grp_pos = grp_pos + 1'b1;
          end
        end
      end
      if (owed.size() > owed_before) begin
        tail = owed.pop_back();
        tail.last = 1'b1;
        owed.push_back(tail);
      end
    endfunction

    task report_mismatch(string msg);
      fail_count++;
      $display("mismatch at result %0d: %s", results_checked, msg);
    endtask

    // compare one output transaction with the oldest owed result
    task check_result(uu_out_t got);
      uu_out_t want;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h is_data %0b done %0b",
                                  got.data_byte, got.is_data, got.done));
        return;
      end
      want = owed.pop_front();
      results_checked++;
      if (got.data_byte !== want.data_byte)
        report_mismatch($sformatf("data_byte %02h, expected %02h",
                                  got.data_byte, want.data_byte));
      if (got.is_data !== want.is_data)
        report_mismatch($sformatf("is_data %0b, expected %0b", got.is_data, want.is_data));
      if (got.done !== want.done)
        report_mismatch($sformatf("done_res %0b, expected %0b", got.done, want.done));
      if (got.err !== want.err)
        report_mismatch($sformatf("decode_error %0b, expected %0b", got.err, want.err));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] char_code = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] data_byte;
  logic       is_data;
  logic       done_res;
  logic       decode_error;
  logic       last;

  uu_decode_board board;
  int unsigned    send_idle = 0;
  int unsigned    recv_idle = 0;
  int unsigned    items_sent = 0;
  int unsigned    cycle_count = 0;

  uu_line_decoder_top #(
    .MAX_LINE_CHARS(MAX_LINE_CHARS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .char_code(char_code),
    .end_of_text(end_of_text),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .data_byte(data_byte),
    .is_data(is_data),
    .done_res(done_res),
    .decode_error(decode_error),
    .last(last)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // accepted transactions on both channels, input side first
  always @(posedge clk) begin : watch_channels
    uu_out_t seen;
    if (!rst) begin
      if (in_valid && in_ready) board.note_char(char_code, end_of_text);
      if (out_valid && out_ready) begin
        seen = {data_byte, is_data, done_res, decode_error, last};
        board.check_result(seen);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still owed",
             cycle_count, board.owed.size());
    $display("*** FAILED ***");
    $finish;
  end

  // one input transaction, with random sender gaps ahead of it
  task send_item(input logic [7:0] c, input logic eot);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    char_code   <= c;
    end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task send_char(input logic [7:0] c);
    send_item(c, 1'b0);
  endtask

  task send_end();
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  function logic [7:0] good_char();
    return CHAR_SPACE + 8'($urandom_range(64));
  endfunction

  // outside the sextet range, never a newline
  function logic [7:0] bad_char();
    int unsigned v;
    v = $urandom_range(190);
    if (v < CHAR_SPACE) return (v == CHAR_NEWLINE) ? 8'h00 : 8'(v);
    return 8'(v - CHAR_SPACE + CHAR_LAST_VALID + 1);
  endfunction

  // first character that does not announce a length
  function logic [7:0] skip_char();
    logic [7:0] c;
    c = CHAR_NEWLINE;
    while (c == CHAR_NEWLINE || (c > CHAR_SPACE && c <= CHAR_LAST_LEN))
      c = 8'($urandom_range(255));
    return c;
  endfunction

  // corner lines
  task run_directed();
    send_end();
    // one byte announced, surplus bytes of the group dropped
    send_char(CHAR_SPACE + 8'd1);
    send_char(CHAR_LAST_VALID);
    send_char(CHAR_LAST_VALID - 8'd1);
    send_char(CHAR_SPACE);
    send_char(CHAR_LAST_LEN);
    send_char(CHAR_NEWLINE);
    // full length, broken partial group, then zero padding
    send_char(CHAR_LAST_LEN);
    send_char(8'h00);
    send_char(8'h41);
    send_char(8'hFF);
    send_char(CHAR_NEWLINE);
    // skipped lines at both sides of the length range
    send_char(CHAR_SPACE);
    send_char(8'h41);
    send_char(CHAR_NEWLINE);
    send_char(CHAR_LAST_LEN + 8'd1);
    send_char(8'h42);
    send_char(CHAR_NEWLINE);
    // high code after one good sextet
    send_char(CHAR_SPACE + 8'd3);
    send_char(8'h41);
    send_char(8'h80);
    send_char(CHAR_NEWLINE);
    // end of text in the middle of a line
    send_char(CHAR_SPACE + 8'd4);
    send_char(8'h5A);
    send_item(8'hFF, 1'b1);
  endtask

  // one random line: mostly well formed, some noise and skipped lines
  task send_random_line();
    int unsigned kind;
    int unsigned n;
    int unsigned body;
    kind = $urandom_range(99);
    if (kind < 8) begin
      send_end();
    end else if (kind < 72) begin
      n = ($urandom_range(3) == 0) ? $urandom_range(1, MAX_LINE_BYTES) : $urandom_range(1, 9);
      body = ((n + 2) / 3) * 4;
      case ($urandom_range(7))
        0: body = body - $urandom_range(1, 3);
        1: body = body + $urandom_range(1, 8);
        default: ;
      endcase
      send_char(CHAR_SPACE + 8'(n));
      repeat (body) send_char(($urandom_range(19) == 0) ? bad_char() : good_char());
      if ($urandom_range(15) == 0) send_end();
      else send_char(CHAR_NEWLINE);
    end else if (kind < 86) begin
      repeat ($urandom_range(6)) send_char(8'($urandom_range(255)));
      send_char(CHAR_NEWLINE);
    end else begin
      send_char(skip_char());
      repeat ($urandom_range(5)) send_char(good_char());
      send_char(CHAR_NEWLINE);
    end
  endtask

  task run_random_texts(input int unsigned budget);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < budget) send_random_line();
    send_end();
  endtask

  // a line at the character limit, or one character past it
  task send_limit_text(input bit overflow);
    send_char(CHAR_LAST_LEN);
    repeat (MAX_LINE_CHARS - 1) send_char(good_char());
    if (overflow) begin
      send_char(good_char());
      send_char(CHAR_NEWLINE);
      send_char(bad_char());
      send_char(CHAR_LAST_LEN);
    end
    send_char(CHAR_NEWLINE);
    send_end();
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // sender idles less than receiver
    send_idle = 34;
    recv_idle = 54;
    run_directed();
    run_random_texts(30);

    // receiver idles less than sender
    send_idle = 54;
    recv_idle = 34;
    run_random_texts(30);

    // no idling on either side
    send_idle = 0;
    recv_idle = 0;
    run_random_texts(30);
    send_limit_text(1'b1);

    @(negedge clk);
    in_valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d input transactions over %0d texts, %0d results checked",
             items_sent, board.texts_done, board.results_checked);
    $display("summary: %0d texts hit the line-length error; idling 34/54, 54/34, none",
             board.texts_failed);
    if (board.fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
